/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on a rising edge and muted in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define DSD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication: cons must hold in the cycle after ante.
`define DSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

/* rtl/dsd_pkg.sv */
// ----------------------------------------------------------------------------
// dsd_pkg
// Shared constants and codes for the DLE/STX packet deframer.
// ----------------------------------------------------------------------------
package dsd_pkg;

    localparam logic [7:0] START_DLE        = 8'h10;
    localparam logic [7:0] START_STX        = 8'h02;
    localparam logic [7:0] HEADER_AND_TAIL  = 8'd7;
    localparam logic [7:0] MAX_PACKET_RESET = 8'd22;

    typedef enum logic [1:0] {
        ST_BUSY       = 2'd0,
        ST_VALID      = 2'd1,
        ST_BAD_HEADER = 2'd2,
        ST_BAD_SUM    = 2'd3
    } t_status;

endpackage

/* rtl/dsd_in_if.sv */
// ----------------------------------------------------------------------------
// dsd_in_if
// Byte input channel: valid/ready plus one received byte.
// ----------------------------------------------------------------------------
interface dsd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

/* rtl/dsd_out_if.sv */
// ----------------------------------------------------------------------------
// dsd_out_if
// Result channel: passed-through byte with framing flags and header fields.
// ----------------------------------------------------------------------------
interface dsd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       is_payload;
    logic       packet_done;
    logic [1:0] status;
    logic [7:0] payload_length;
    logic [7:0] command_code;

    modport source (output valid, output data_byte, output is_payload,
                    output packet_done, output status, output payload_length,
                    output command_code, input ready);
    modport sink   (input valid, input data_byte, input is_payload,
                    input packet_done, input status, input payload_length,
                    input command_code, output ready);
endinterface

/* rtl/dsd_cfg_if.sv */
// ----------------------------------------------------------------------------
// dsd_cfg_if
// Configuration write channel for the maximum packet length register.
// ----------------------------------------------------------------------------
interface dsd_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/dle_stx_packet_deframer_top.sv */
// ----------------------------------------------------------------------------
// dle_stx_packet_deframer_top
// Byte-serial deframer for DLE STX CMD LEN PAYLOAD CHECKSUM TAIL TAIL packets.
// ----------------------------------------------------------------------------
// Takes one byte per request on i_rx and returns exactly one result per byte
// on o_res, in order: the byte itself, a payload mark, and on the last tail
// byte (or on a rejected header) a done flag with a status code. One byte
// is taken per clock while the sink keeps ready high; each result is
// registered and shows in the cycle after accept, and the result register
// frees up in the same cycle it is taken. The framing state
// (phase, byte counter, XOR sum) updates at accept, so the per-byte work is
// one compare/XOR/decrement in front of the result register. Headers whose
// total size 7 + LEN exceeds max_packet_length (reset 22) are rejected; a
// bad byte after 0x10 is rejected and re-examined as a start byte. The
// config channel is always ready and should only be written while idle.
// ----------------------------------------------------------------------------
module dle_stx_packet_deframer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dsd_in_if.sink      i_rx,
    dsd_cfg_if.sink     i_cfg,
    dsd_out_if.source   o_res
);

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_STX,
        PH_CMD,
        PH_LEN,
        PH_PAYLOAD,
        PH_CHECK,
        PH_TAIL1,
        PH_TAIL2
    } t_phase;

    // framing state
    t_phase     r_phase,      n_phase;
    logic [7:0] r_bytes_left, n_bytes_left;
    logic [7:0] r_len,        n_len;
    logic [7:0] r_cmd,        n_cmd;
    logic [7:0] r_xor,        n_xor;
    logic       r_sum_ok,     n_sum_ok;
    logic [7:0] r_max_len;

    // result register
    logic            r_valid;
    logic [7:0]      r_data;
    logic            r_payload,  n_payload;
    logic            r_done,     n_done;
    dsd_pkg::t_status r_status,  n_status;

    logic       w_accept;
    logic [8:0] w_total;

    // result register drains or is empty: room for the next byte
    assign i_rx.ready  = !r_valid || o_res.ready;
    assign w_accept    = i_rx.valid && i_rx.ready;
    assign i_cfg.ready = 1'b1;

    // announced packet size, one bit wider so it cannot wrap
    assign w_total = {1'b0, dsd_pkg::HEADER_AND_TAIL} + {1'b0, i_rx.rx_byte};

    always_comb begin
        n_phase      = r_phase;
        n_bytes_left = r_bytes_left;
        n_len        = r_len;
        n_cmd        = r_cmd;
        n_xor        = r_xor;
        n_sum_ok     = r_sum_ok;
        n_payload    = 1'b0;
        n_done       = 1'b0;
        n_status     = dsd_pkg::ST_BUSY;
        unique case (r_phase)
            PH_HUNT: begin
                if (i_rx.rx_byte == dsd_pkg::START_DLE) begin
                    n_phase = PH_STX;
                end
            end
            PH_STX: begin
                if (i_rx.rx_byte == dsd_pkg::START_STX) begin
                    n_phase = PH_CMD;
                end else begin
                    // reject, but a repeated DLE may still open a packet
                    n_done   = 1'b1;
                    n_status = dsd_pkg::ST_BAD_HEADER;
                    n_phase  = (i_rx.rx_byte == dsd_pkg::START_DLE) ? PH_STX : PH_HUNT;
                end
            end
            PH_CMD: begin
                n_cmd   = i_rx.rx_byte;
                n_phase = PH_LEN;
            end
            PH_LEN: begin
                n_len    = i_rx.rx_byte;
                n_xor    = '0;
                n_sum_ok = 1'b0;
                if (w_total > {1'b0, r_max_len}) begin
                    n_done   = 1'b1;
                    n_status = dsd_pkg::ST_BAD_HEADER;
                    n_phase  = PH_HUNT;
                end else begin
                    n_bytes_left = i_rx.rx_byte;
                    n_phase      = (i_rx.rx_byte == 8'd0) ? PH_CHECK : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                n_payload    = 1'b1;
                n_xor        = r_xor ^ i_rx.rx_byte;
                n_bytes_left = r_bytes_left - 8'd1;
                if (r_bytes_left == 8'd1) begin
                    n_phase = PH_CHECK;
                end
            end
            PH_CHECK: begin
                n_sum_ok = (i_rx.rx_byte == r_xor);
                n_phase  = PH_TAIL1;
            end
            PH_TAIL1: begin
                n_phase = PH_TAIL2;
            end
            PH_TAIL2: begin
                n_done   = 1'b1;
                n_status = r_sum_ok ? dsd_pkg::ST_VALID : dsd_pkg::ST_BAD_SUM;
                n_phase  = PH_HUNT;
            end
            default: begin
                n_phase = PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HUNT;
            r_bytes_left <= '0;
            r_len        <= '0;
            r_cmd        <= '0;
            r_xor        <= '0;
            r_sum_ok     <= 1'b0;
            r_max_len    <= dsd_pkg::MAX_PACKET_RESET;
            r_valid      <= 1'b0;
            r_data       <= '0;
            r_payload    <= 1'b0;
            r_done       <= 1'b0;
            r_status     <= dsd_pkg::ST_BUSY;
        end else begin
            if (i_cfg.valid) begin
                r_max_len <= i_cfg.data;
            end
            if (w_accept) begin
                r_phase      <= n_phase;
                r_bytes_left <= n_bytes_left;
                r_len        <= n_len;
                r_cmd        <= n_cmd;
                r_xor        <= n_xor;
                r_sum_ok     <= n_sum_ok;
                r_valid      <= 1'b1;
                r_data       <= i_rx.rx_byte;
                r_payload    <= n_payload;
                r_done       <= n_done;
                r_status     <= n_status;
            end else if (o_res.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_res.valid          = r_valid;
    assign o_res.data_byte      = r_data;
    assign o_res.is_payload     = r_payload;
    assign o_res.packet_done    = r_done;
    assign o_res.status         = r_status;
    // header fields track the live state, which only moves on accept
    assign o_res.payload_length = r_len;
    assign o_res.command_code   = r_cmd;

endmodule

/* rtl/dsd_checker.sv */
// ----------------------------------------------------------------------------
// dsd_checker
// Port-level checks for the deframer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dsd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_rx_valid,
    input logic       i_rx_ready,
    input logic       i_res_valid,
    input logic       i_res_ready,
    input logic [7:0] i_res_data,
    input logic       i_res_payload,
    input logic       i_res_done,
    input logic [1:0] i_res_status
);

    logic w_rx_accept;
    logic w_res_stall;
    logic w_res_open;
    logic w_status_busy;

    assign w_rx_accept   = i_rx_valid && i_rx_ready;
    assign w_res_stall   = i_res_valid && !i_res_ready;
    assign w_res_open    = i_res_valid && !i_res_done;
    assign w_status_busy = (i_res_status == dsd_pkg::ST_BUSY);

    // one result per byte, in the cycle after accept
    `DSD_ASSERT_NEXT(a_result_follows, i_clk, i_rst_n, w_rx_accept, i_res_valid)

    // a verdict code only appears with the done flag
    `DSD_ASSERT_NOW(a_status_needs_done, i_clk, i_rst_n, w_res_open, w_status_busy)

    // done never lands on a payload byte
    `DSD_ASSERT_NOW(a_done_not_payload, i_clk, i_rst_n, i_res_valid && i_res_payload, !i_res_done)

    // a stalled result holds
    `DSD_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, w_res_stall, i_res_valid && $stable(i_res_data))

endmodule

bind dle_stx_packet_deframer_top dsd_checker u_dsd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_rx_valid    (i_rx.valid),
    .i_rx_ready    (i_rx.ready),
    .i_res_valid   (o_res.valid),
    .i_res_ready   (o_res.ready),
    .i_res_data    (o_res.data_byte),
    .i_res_payload (o_res.is_payload),
    .i_res_done    (o_res.packet_done),
    .i_res_status  (o_res.status)
);
